// ===== design/scg_pkg.sv =====
// scg_pkg: shared types, constants and table functions of the sine/cosine generator
// no dependencies; imported by every module of the block
package scg_pkg;

    // default sizes of the phase path, the sine table and the output sample
    localparam int PHASE_BITS_DEFAULT       = 32;
    localparam int TABLE_INDEX_BITS_DEFAULT = 12;
    localparam int SAMPLE_BITS_DEFAULT      = 16;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration port
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int AMP_BITS      = 15;
    localparam int WAVE_BITS     = 2;

    // table entries and product width
    localparam int TAB_VALUE_BITS = 15;
    localparam int PRODUCT_BITS   = 32;
    localparam int PRODUCT_SHIFT  = 15;

    // register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_PHASE_STEP   = 2'd0,
        REG_PHASE_OFFSET = 2'd1,
        REG_AMPLITUDE    = 2'd2,
        REG_WAVE_SELECT  = 2'd3
    } cfg_reg_e;

    // wave selector codes
    localparam logic [WAVE_BITS-1:0] WAVE_COSINE = 2'd0;
    localparam logic [WAVE_BITS-1:0] WAVE_SINE   = 2'd1;
    localparam logic [WAVE_BITS-1:0] WAVE_ZERO   = 2'd2;

    // one configuration write
    typedef struct packed {
        logic                     we;
        cfg_reg_e                 addr;
        logic [CFG_DATA_BITS-1:0] data;
    } cfg_wr_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // half pi in Q61
    localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
    localparam logic [63:0] LOW32       = 64'h00000000FFFFFFFF;

    // Q61 by Q61 product, truncated back to Q61
    function automatic logic [63:0] scg_q61_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] a0, a1, b0, b1, p00, p01, p10, p11, mid, lo, hi;
        a0  = a & LOW32;
        a1  = a >> 32;
        b0  = b & LOW32;
        b1  = b >> 32;
        p00 = a0 * b0;
        p01 = a0 * b1;
        p10 = a1 * b0;
        p11 = a1 * b1;
        mid = (p00 >> 32) + (p01 & LOW32) + (p10 & LOW32);
        lo  = (mid << 32) | (p00 & LOW32);
        hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
        return (hi << 3) | (lo >> 61);
    endfunction

    // round(32767*sin(k * pi/2 / 2^qshift)) by a Taylor series, evaluated at elaboration
    function automatic logic [TAB_VALUE_BITS-1:0] scg_quarter_value(input logic [63:0] k,
                                                                    input int qshift);
        logic [63:0] qmask, x, x2, term, sum, a, b, r;
        qmask = (64'd1 << qshift) - 64'd1;
        x     = (HALF_PI_Q61 >> qshift) * k + (((HALF_PI_Q61 & qmask) * k) >> qshift);
        x2    = scg_q61_mul(x, x);
        term  = x;
        sum   = x;
        for (int n = 3; n <= 27; n += 2) begin
            term = scg_q61_mul(term, x2) / 64'((n - 1) * n);
            if (((n >> 1) & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        a = 64'd32767 * (sum >> 32);
        b = 64'd32767 * (sum & LOW32);
        r = (a + (b >> 32) + (64'd1 << 28)) >> 29;
        return r[TAB_VALUE_BITS-1:0];
    endfunction

endpackage

// ===== design/scg_queue.sv =====
// scg_queue: small first-in first-out queue between front and back
// uses scg_pkg for the status struct
module scg_queue
    import scg_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              pop,
    output logic [WIDTH-1:0]  rd_data,
    output queue_status_t     status
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0]   LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] FULL_CNT = COUNT_BITS'(DEPTH);

    logic [WIDTH-1:0]      mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    // pushes are refused when full, pops when empty
    assign do_push = push && (count_reg != FULL_CNT);
    assign do_pop  = pop && (count_reg != '0);

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign rd_data      = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/scg_front.sv =====
// scg_front: configuration registers, phase accumulator and request classification
// uses scg_pkg; pushes table index and zero flag into scg_queue
module scg_front
    import scg_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEFAULT,
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cfg_wr_t                     cfg_wr,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        restart,
    input  queue_status_t               q_status,
    output logic                        q_push,
    output logic [TABLE_INDEX_BITS:0]   q_entry,
    output logic [AMP_BITS-1:0]         amplitude
);

    localparam logic [PHASE_BITS-1:0] QUARTER_TURN = {2'b01, {(PHASE_BITS - 2){1'b0}}};

    logic [31:0]           phase_step_reg;
    logic [31:0]           phase_offset_reg;
    logic [AMP_BITS-1:0]   amplitude_reg;
    logic [WAVE_BITS-1:0]  wave_reg;
    logic [PHASE_BITS-1:0] acc_reg, acc_next;
    logic [PHASE_BITS-1:0] base, phase, quarter;
    logic                  is_cos, active, accept;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= '0;
            phase_offset_reg <= '0;
            amplitude_reg    <= '0;
            wave_reg         <= WAVE_SINE;
        end else if (cfg_wr.we) begin
            unique case (cfg_wr.addr)
                REG_PHASE_STEP:   phase_step_reg   <= cfg_wr.data[31:0];
                REG_PHASE_OFFSET: phase_offset_reg <= cfg_wr.data[31:0];
                REG_AMPLITUDE:    amplitude_reg    <= cfg_wr.data[AMP_BITS-1:0];
                REG_WAVE_SELECT:  wave_reg         <= cfg_wr.data[WAVE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign amplitude = amplitude_reg;

    // request classification
    assign is_cos  = (wave_reg == WAVE_COSINE);
    assign active  = is_cos || (wave_reg == WAVE_SINE);
    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    // phase of this request and next accumulator value
    assign base     = restart ? '0 : acc_reg;
    assign quarter  = is_cos ? QUARTER_TURN : '0;
    assign phase    = base + PHASE_BITS'(phase_offset_reg) + quarter;
    assign acc_next = base + PHASE_BITS'(phase_step_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (accept) begin
            acc_reg <= acc_next;
        end
    end

    // queue entry: zero flag above the table index
    assign q_push  = accept;
    assign q_entry = {!active, phase[PHASE_BITS-1 -: TABLE_INDEX_BITS]};

endmodule

// ===== design/scg_back.sv =====
// scg_back: quarter-wave table read, amplitude multiply, shift and clamp, output register
// uses scg_pkg for the table function; pops entries from scg_queue
module scg_back
    import scg_pkg::*;
#(
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEFAULT,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [TABLE_INDEX_BITS:0]   q_entry,
    input  queue_status_t               q_status,
    output logic                        q_pop,
    input  logic [AMP_BITS-1:0]         amplitude,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [SAMPLE_BITS-1:0]      m_sample
);

    localparam int QSHIFT  = TABLE_INDEX_BITS - 2;
    localparam int QDEPTH  = (1 << QSHIFT) + 1;
    localparam int ADDR_W  = TABLE_INDEX_BITS - 1;
    localparam logic [ADDR_W-1:0] QUARTER = {1'b1, {QSHIFT{1'b0}}};
    localparam int SMAX    = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SMIN    = -SMAX - 1;

    typedef logic [TAB_VALUE_BITS-1:0] qtab_t [QDEPTH];

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int k = 0; k < QDEPTH; k++) begin
            t[k] = scg_quarter_value(64'(k), QSHIFT);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    logic                        en;
    logic [1:0]                  quad;
    logic [QSHIFT-1:0]           rem;
    logic [ADDR_W-1:0]           addr;
    logic [TAB_VALUE_BITS-1:0]   rom_q_reg;
    logic                        v1_reg, neg1_reg, zero1_reg;
    logic signed [15:0]          rom_signed;
    logic signed [PRODUCT_BITS-1:0] amp_ext, rom_ext;
    logic signed [PRODUCT_BITS-1:0] prod_next, prod_reg;
    logic                        v2_reg, zero2_reg;
    logic signed [PRODUCT_BITS-1:0] shifted;
    logic [SAMPLE_BITS-1:0]      sample_next, sample_reg;
    logic                        valid_reg;

    // whole pipeline moves when the output register is free or being taken
    assign en    = !valid_reg || m_ready;
    assign q_pop = en && !q_status.empty;

    // quadrant mirror of the table address
    assign quad = q_entry[TABLE_INDEX_BITS-1 -: 2];
    assign rem  = q_entry[QSHIFT-1:0];
    assign addr = quad[0] ? (QUARTER - {1'b0, rem}) : {1'b0, rem};

    // table read stage
    always_ff @(posedge aclk) begin
        if (en) begin
            rom_q_reg <= QTAB[addr];
            neg1_reg  <= quad[1];
            zero1_reg <= q_entry[TABLE_INDEX_BITS];
        end
    end

    // multiply stage, operands sign-extended to the product width first
    assign rom_signed = neg1_reg ? -$signed({1'b0, rom_q_reg}) : $signed({1'b0, rom_q_reg});
    assign amp_ext    = PRODUCT_BITS'($signed({1'b0, amplitude}));
    assign rom_ext    = PRODUCT_BITS'(rom_signed);
    assign prod_next  = amp_ext * rom_ext;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            zero2_reg <= zero1_reg;
        end
    end

    // floor shift and clamp to the sample range
    assign shifted = prod_reg >>> PRODUCT_SHIFT;

    always_comb begin
        if (zero2_reg) begin
            sample_next = '0;
        end else if (shifted > SMAX) begin
            sample_next = SAMPLE_BITS'(SMAX);
        end else if (shifted < SMIN) begin
            sample_next = SAMPLE_BITS'(SMIN);
        end else begin
            sample_next = shifted[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sample_reg <= sample_next;
        end
    end

    // valid bits of the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= q_pop;
            v2_reg    <= v1_reg;
            valid_reg <= v2_reg;
        end
    end

    assign m_valid  = valid_reg;
    assign m_sample = sample_reg;

endmodule

// ===== design/sine_cosine_generator.sv =====
// Sine/cosine generator: phase-accumulator synthesiser producing one sample per request.
// Input channel s_axis_*: each request carries a restart flag (tdata bit 0) that zeroes
// the accumulated phase for that sample. Output channel m_axis_*: one signed sample per
// request, in order. Configuration port cfg_*: plain writes of phase step, phase offset,
// amplitude and wave selector; the user must write them only while no request is in flight,
// the block itself does not enforce this.
// Pipeline: queue, table read, multiply and output register, in that order.
// Throughput: one request per cycle while s_axis_tready is high, set by the phase accumulator
// update in the front and the fully pipelined table read and multiply in the back.
// Reset: phase accumulator, step, offset and amplitude clear, selector set to sine,
// queue and pipeline empty; no clearing pass.
// Stalls: while m_axis_tready is low the back pipeline holds; the four-entry queue keeps
// taking requests until it fills, then s_axis_tready drops.
// Depends on scg_pkg, scg_front, scg_queue, scg_back.
module sine_cosine_generator
    import scg_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEFAULT,
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEFAULT,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [0] restart, rest zero
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,  // sample, then zero fill
    input  logic                         cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]     cfg_wdata
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    cfg_wr_t                     cfg_wr;
    queue_status_t               q_status;
    logic                        q_push, q_pop;
    logic [TABLE_INDEX_BITS:0]   q_wr_entry, q_rd_entry;
    logic [AMP_BITS-1:0]         amplitude;
    logic [SAMPLE_BITS-1:0]      sample;

    assign cfg_wr.we   = cfg_we;
    assign cfg_wr.addr = cfg_reg_e'(cfg_addr);
    assign cfg_wr.data = cfg_wdata;

    scg_front #(
        .PHASE_BITS       (PHASE_BITS),
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .restart   (s_axis_tdata[0]),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_entry   (q_wr_entry),
        .amplitude (amplitude)
    );

    scg_queue #(
        .WIDTH (TABLE_INDEX_BITS + 1),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_entry),
        .pop     (q_pop),
        .rd_data (q_rd_entry),
        .status  (q_status)
    );

    scg_back #(
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_entry   (q_rd_entry),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .amplitude (amplitude),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_sample  (sample)
    );

    // zero fill above the sample
    assign m_axis_tdata = TDATA_BITS'(sample);

endmodule

// ===== design/scg_checker.sv =====
// scg_checker: port-level assertions for the sine/cosine generator
// uses scg_pkg for register and wave codes; bound to sine_cosine_generator below
module scg_checker
    import scg_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input logic                         cfg_we,
    input logic [CFG_ADDR_BITS-1:0]     cfg_addr,
    input logic [CFG_DATA_BITS-1:0]     cfg_wdata
);

    logic [7:0] pending_reg;
    logic       amp_zero_reg;
    logic       wave_quiet_reg;
    logic       in_req, out_req;

    assign in_req  = s_axis_tvalid && s_axis_tready;
    assign out_req = m_axis_tvalid && m_axis_tready;

    // requests accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (in_req && !out_req) begin
            pending_reg <= pending_reg + 1'b1;
        end else if (out_req && !in_req) begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // track settings that force a silent output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_zero_reg   <= 1'b1;
            wave_quiet_reg <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_addr == REG_AMPLITUDE) begin
                amp_zero_reg <= (cfg_wdata[AMP_BITS-1:0] == '0);
            end
            if (cfg_addr == REG_WAVE_SELECT) begin
                wave_quiet_reg <= cfg_wdata[1];
            end
        end
    end

    // nothing is offered straight after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a stalled sample holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled sample changed");

    // no sample without an outstanding request
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> pending_reg != '0)
        else $error("sample without request");

    // zero amplitude or the zero or spare selector gives silent samples
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (amp_zero_reg || wave_quiet_reg)
            |-> m_axis_tdata[SAMPLE_BITS-1:0] == '0)
        else $error("non-zero sample while silent");

endmodule

bind sine_cosine_generator scg_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_scg_checker (.*);

// ===== tb/tb_sine_cosine_generator.sv =====
// tb_sine_cosine_generator: self-checking bench for the sine/cosine generator
// depends on scg_pkg and sine_cosine_generator; holds stimulus, sample predictor and checks
module tb_sine_cosine_generator;
    import scg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W       = SAMPLE_BITS_DEFAULT;
    localparam int TDATA_W        = ((SAMPLE_W + 7) / 8) * 8;
    localparam int SAMPLE_MAX     = 2 ** (SAMPLE_W - 1) - 1;
    localparam int SAMPLE_MIN     = -(2 ** (SAMPLE_W - 1));
    localparam int QUARTER_POINTS = 1024;
    localparam int RANDOM_ITEMS   = 900;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam int PRINT_CAP      = 20;
    localparam int DIRECTED_ROWS  = 23;

    localparam logic [63:0]          PI_OVER_2_Q61 = 64'h3243F6A8885A308D;
    localparam logic [31:0]          QUARTER_TURN  = 32'h4000_0000;
    localparam logic [WAVE_BITS-1:0] WAVE_SPARE    = 2'd3;

    // one directed request with the settings it runs under
    typedef struct packed {
        logic                    setup;
        logic [31:0]             step;
        logic [31:0]             offset;
        logic [AMP_BITS-1:0]     amp;
        logic [WAVE_BITS-1:0]    wave;
        logic                    restart;
        logic                    known;
        logic [SAMPLE_W-1:0]     want;
    } plan_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata;   // [0] restart, rest zero
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [TDATA_W-1:0]       m_axis_tdata;   // [15:0] sample
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    // predictor state and register copies
    logic signed [SAMPLE_W-1:0] quarter_wave [0:QUARTER_POINTS];
    logic [31:0]                acc_phase;
    logic [31:0]                step_reg;
    logic [31:0]                offset_reg;
    logic [AMP_BITS-1:0]        amp_reg;
    logic [WAVE_BITS-1:0]       wave_reg;

    logic [TDATA_W-1:0] pending_samples [$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    int                 send_gap_max = 0;
    int                 recv_gap_max = 0;
    int                 long_hold = 0;

    // directed requests: after reset, peaks, zero crossings, spare selector, wrap cases
    plan_row_t plan [0:DIRECTED_ROWS-1] = '{
        '{1'b0, 32'h0,         32'h0,         15'd0,     WAVE_SINE,   1'b0, 1'b1, 16'h0000},
        '{1'b1, 32'h0,         32'h0,         15'd32767, WAVE_SINE,   1'b1, 1'b1, 16'h0000},
        '{1'b1, 32'h0,         32'h4000_0000, 15'd32767, WAVE_SINE,   1'b1, 1'b1, 16'h7FFE},
        '{1'b1, 32'h0,         32'h8000_0000, 15'd32767, WAVE_SINE,   1'b1, 1'b1, 16'h0000},
        '{1'b1, 32'h0,         32'hC000_0000, 15'd32767, WAVE_SINE,   1'b1, 1'b1, 16'h8001},
        '{1'b1, 32'h0,         32'h0,         15'd32767, WAVE_COSINE, 1'b1, 1'b1, 16'h7FFE},
        '{1'b1, 32'h0,         32'h4000_0000, 15'd32767, WAVE_COSINE, 1'b1, 1'b1, 16'h0000},
        '{1'b1, 32'h0,         32'h8000_0000, 15'd32767, WAVE_COSINE, 1'b1, 1'b1, 16'h8001},
        '{1'b1, 32'h0,         32'h4000_0000, 15'd1,     WAVE_SINE,   1'b1, 1'b1, 16'h0000},
        '{1'b1, 32'h0,         32'hC000_0000, 15'd1,     WAVE_SINE,   1'b1, 1'b1, 16'hFFFF},
        '{1'b1, 32'h0,         32'h4000_0000, 15'd0,     WAVE_SINE,   1'b1, 1'b1, 16'h0000},
        '{1'b1, 32'h1234_5678, 32'h4000_0000, 15'd32767, WAVE_ZERO,   1'b1, 1'b1, 16'h0000},
        '{1'b1, 32'h1234_5678, 32'h4000_0000, 15'd32767, WAVE_SPARE,  1'b0, 1'b1, 16'h0000},
        '{1'b1, 32'h1234_5678, 32'h0,         15'd32767, WAVE_SINE,   1'b0, 1'b0, 16'h0000},
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'd32767, WAVE_SINE,   1'b1, 1'b0, 16'h0000},
        '{1'b0, 32'h0,         32'h0,         15'd0,     WAVE_SINE,   1'b0, 1'b0, 16'h0000},
        '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'd32767, WAVE_COSINE, 1'b0, 1'b0, 16'h0000},
        '{1'b1, 32'h8000_0000, 32'h0,         15'd32767, WAVE_SINE,   1'b1, 1'b0, 16'h0000},
        '{1'b0, 32'h0,         32'h0,         15'd0,     WAVE_SINE,   1'b0, 1'b0, 16'h0000},
        '{1'b1, 32'h0010_0000, 32'h3FF0_0000, 15'd32767, WAVE_SINE,   1'b1, 1'b0, 16'h0000},
        '{1'b0, 32'h0,         32'h0,         15'd0,     WAVE_SINE,   1'b0, 1'b0, 16'h0000},
        '{1'b1, 32'h0010_0000, 32'hBFF0_0000, 15'd20000, WAVE_COSINE, 1'b1, 1'b0, 16'h0000},
        '{1'b1, 32'h0000_0001, 32'h000F_FFFF, 15'd32767, WAVE_SINE,   1'b0, 1'b0, 16'h0000}
    };

    sine_cosine_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Q61 product truncated back to Q61
    function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = {64'd0, a} * {64'd0, b};
        return wide[124:61];
    endfunction

    // quarter-wave point k: rounded 32767*sin(k*pi/2/1024) by an odd Taylor series
    function automatic int quarter_point(input int k);
        logic [127:0] wide;
        logic [63:0]  x, x2, term, total;
        wide  = {64'd0, PI_OVER_2_Q61} * 128'(k);
        x     = wide[73:10];
        x2    = fix_mul(x, x);
        term  = x;
        total = x;
        for (int n = 3; n <= 27; n += 2) begin
            term = fix_mul(term, x2) / 64'((n - 1) * n);
            if (((n >> 1) & 1) == 1) begin
                total = total - term;
            end else begin
                total = total + term;
            end
        end
        wide = ({64'd0, total} * 128'd32767 + (128'd1 << 60)) >> 61;
        return int'(wide[31:0]);
    endfunction

    // full-turn sine from the quarter table, mirrored by quadrant
    function automatic int table_sine(input logic [11:0] idx);
        int mag;
        if (idx[10]) begin
            mag = quarter_wave[QUARTER_POINTS - int'(idx[9:0])];
        end else begin
            mag = quarter_wave[int'(idx[9:0])];
        end
        return idx[11] ? -mag : mag;
    endfunction

    // sample for one request, then advance the phase
    function automatic logic [TDATA_W-1:0] predict_sample(input logic restart);
        logic [31:0]        ph;
        logic [TDATA_W-1:0] word;
        int                 prod;
        int                 s;
        s = 0;
        if (restart) begin
            acc_phase = '0;
        end
        if (wave_reg == WAVE_COSINE || wave_reg == WAVE_SINE) begin
            ph = acc_phase + offset_reg;
            if (wave_reg == WAVE_COSINE) begin
                ph = ph + QUARTER_TURN;
            end
            prod = int'(amp_reg) * table_sine(ph[31:20]);
            s    = prod >>> 15;
            if (s > SAMPLE_MAX) s = SAMPLE_MAX;
            if (s < SAMPLE_MIN) s = SAMPLE_MIN;
        end
        acc_phase = acc_phase + step_reg;
        word = '0;
        word[SAMPLE_W-1:0] = s[SAMPLE_W-1:0];
        return word;
    endfunction

    task automatic report_mismatch(input string what, input logic [TDATA_W-1:0] got,
                                   input logic [TDATA_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at %0t: %s: got %h, expected %h", $realtime, what, got, want);
        end
    endtask

    // offer one request after a random gap and record its expected sample on acceptance
    task automatic send_request(input logic restart, input logic known,
                                input logic [SAMPLE_W-1:0] want);
        int                 gap;
        logic [TDATA_W-1:0] word;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_axis_tready);
        word = predict_sample(restart);
        if (known) begin
            word = '0;
            word[SAMPLE_W-1:0] = want;
        end
        pending_samples.push_back(word);
    endtask

    // stop offering and wait for every outstanding sample
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // write all four registers while idle and mirror them
    task automatic write_settings(input logic [31:0] step, input logic [31:0] offset,
                                  input logic [AMP_BITS-1:0] amp,
                                  input logic [WAVE_BITS-1:0] wave);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_PHASE_OFFSET, offset);
        write_reg(REG_AMPLITUDE, CFG_DATA_BITS'(amp));
        write_reg(REG_WAVE_SELECT, CFG_DATA_BITS'(wave));
        cfg_we     <= 1'b0;
        step_reg   = step;
        offset_reg = offset;
        amp_reg    = amp;
        wave_reg   = wave;
    endtask

    // result sink: random stall before each sample, long hold on request
    initial begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = $urandom_range(0, recv_gap_max);
            if (long_hold > 0) begin
                stall     = long_hold;
                long_hold = 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // compare each accepted sample with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("sample with none pending", m_axis_tdata, '0);
            end else if (m_axis_tdata !== pending_samples[0]) begin
                report_mismatch("sample", m_axis_tdata, pending_samples.pop_front());
            end else begin
                void'(pending_samples.pop_front());
            end
        end
    end

    // watchdog on cycles with no request or sample moving
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // main sequence
    initial begin
        int                   sent;
        int                   run;
        int                   burst;
        logic [31:0]          step;
        logic [31:0]          offset;
        logic [AMP_BITS-1:0]  amp;
        logic [WAVE_BITS-1:0] wave;
        logic                 restart;

        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= REG_PHASE_STEP;
        cfg_wdata     <= '0;

        for (int k = 0; k <= QUARTER_POINTS; k++) begin
            quarter_wave[k] = SAMPLE_W'(quarter_point(k));
        end
        acc_phase  = '0;
        step_reg   = '0;
        offset_reg = '0;
        amp_reg    = '0;
        wave_reg   = WAVE_SINE;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, one request at a time with gaps on both sides
        send_gap_max = 15;
        recv_gap_max = 15;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            drain();
            if (plan[r].setup) begin
                write_settings(plan[r].step, plan[r].offset, plan[r].amp, plan[r].wave);
            end
            send_request(plan[r].restart, plan[r].known, plan[r].want);
        end

        // random bursts, each under fresh settings and idling
        sent = 0;
        run  = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            case ($urandom_range(0, 5))
                0:       step = '0;
                1:       step = 32'hFFFF_FFFF;
                2:       step = $urandom_range(1, 4096);
                3:       step = 32'h0010_0000 * $urandom_range(1, 64);
                default: step = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0:       offset = '0;
                1:       offset = 32'hFFFF_FFFF;
                default: offset = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       amp = '0;
                1:       amp = 15'd32767;
                default: amp = AMP_BITS'($urandom_range(1, 32767));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: wave = WAVE_COSINE;
                8:          wave = WAVE_ZERO;
                9:          wave = WAVE_SPARE;
                default:    wave = WAVE_SINE;
            endcase
            write_settings(step, offset, amp, wave);

            send_gap_max = $urandom_range(0, 1) ? 15 : 0;
            recv_gap_max = $urandom_range(0, 1) ? 15 : 0;
            burst        = $urandom_range(20, 120);
            // back-pressure run: sink holds off while requests keep coming
            if (run == 1) begin
                long_hold    = LONG_HOLD;
                send_gap_max = 0;
                burst        = 60;
            end

            for (int i = 0; i < burst; i++) begin
                if (i == 0) begin
                    restart = 1'($urandom_range(0, 1));
                end else begin
                    restart = ($urandom_range(0, 15) == 0);
                end
                send_request(restart, 1'b0, '0);
                if ($urandom_range(0, 63) == 0) begin
                    drain();
                end
            end
            sent += burst;
            run++;
        end

        drain();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/scg_pkg.sv
design/scg_queue.sv
design/scg_front.sv
design/scg_back.sv
design/sine_cosine_generator.sv
design/scg_checker.sv
tb/tb_sine_cosine_generator.sv
